// ===== design/stable_sorted_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stable sorted priority queue
// Clocked property wrappers; they compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define SPQ_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// cond must never be true outside reset
`define SPQ_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPQ_ASSERT(name, clk, rst_n, prop, msg)
`define SPQ_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the stable sorted priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

	localparam int HANDLE_W = 16;
	localparam int PRIO_W   = 12;
	localparam int AGIL_W   = 8;
	localparam int ETYPE_W  = 2;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// request kinds
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	// entry types
	localparam logic [ETYPE_W-1:0] ETYPE_PHYSICAL = 2'd0;
	localparam logic [ETYPE_W-1:0] ETYPE_MAGIC    = 2'd1;
	localparam logic [ETYPE_W-1:0] ETYPE_AGILE    = 2'd2;
	localparam logic [ETYPE_W-1:0] ETYPE_TANK     = 2'd3;

	// result status
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// classified request, front -> back
	typedef struct packed {
		logic                kind;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
	} op_t;

	// one result
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [HANDLE_W-1:0] handle;
		logic [PRIO_W-1:0]   prio;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
	} res_t;

endpackage
`default_nettype wire

// ===== design/spq_fifo.sv =====
// ----------------------------------------------------------------------------
// spq_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spq_fifo (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  spq_pkg::op_t  push_op,
	output logic          full,
	input  wire           pop,
	output spq_pkg::op_t  pop_op,
	output logic          empty
);

	spq_pkg::op_t                 mem_q [spq_pkg::FIFO_DEPTH];
	logic [spq_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [spq_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [spq_pkg::FIFO_AW:0]    cnt_q;

	assign full   = (cnt_q == (spq_pkg::FIFO_AW+1)'(spq_pkg::FIFO_DEPTH));
	assign empty  = (cnt_q == '0);
	assign pop_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/spq_front.sv =====
// ----------------------------------------------------------------------------
// spq_front
// Takes requests off the input stream and works out the scaled priority.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spq_front (
	input  wire           s_tvalid,
	output logic          s_tready,
	input  wire  [31:0]   s_tdata,
	input  wire           s_tuser,
	input  wire           fifo_full,
	output logic          push,
	output spq_pkg::op_t  push_op
);

	logic [spq_pkg::AGIL_W-1:0]  agility;
	logic                        alive;
	logic [spq_pkg::ETYPE_W-1:0] etype;
	logic [spq_pkg::PRIO_W-1:0]  base;
	logic [spq_pkg::PRIO_W-1:0]  prio;

	assign agility = s_tdata[23:16];
	assign alive   = s_tdata[24];
	assign etype   = s_tdata[26:25];
	assign base    = spq_pkg::PRIO_W'(agility);

	// priority times ten: x15 agile, x8 tank, x10 otherwise
	always_comb begin
		case (etype)
			spq_pkg::ETYPE_AGILE: prio = (base << 4) - base;
			spq_pkg::ETYPE_TANK:  prio = base << 3;
			default:              prio = (base << 3) + (base << 1);
		endcase
		if (!alive) begin
			prio = '0;
		end
	end

	assign s_tready       = !fifo_full;
	assign push           = s_tvalid && !fifo_full;
	assign push_op.kind   = s_tuser;
	assign push_op.handle = s_tdata[15:0];
	assign push_op.prio   = prio;

	// pad bits of the request carry nothing
	logic unused_pad;
	assign unused_pad = ^s_tdata[31:27];

endmodule
`default_nettype wire

// ===== design/spq_back.sv =====
// ----------------------------------------------------------------------------
// spq_back
// Sorted row of entry cells plus the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module spq_back #(
	parameter int CAPACITY = 16
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           fifo_empty,
	input  spq_pkg::op_t  op,
	output logic          pop,
	output logic          m_tvalid,
	input  wire           m_tready,
	output spq_pkg::res_t res
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic [spq_pkg::HANDLE_W-1:0] hnd_q [CAPACITY];
	logic [spq_pkg::PRIO_W-1:0]   pri_q [CAPACITY];
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_nx;
	logic [CAPACITY-1:0]          ge;
	logic                         full, empty, do_enq, do_deq, valid_q;
	logic [spq_pkg::STATUS_W-1:0] status_nx;
	logic [spq_pkg::HANDLE_W-1:0] front_hnd;
	logic [spq_pkg::PRIO_W-1:0]   front_pri;

	assign full   = (count_q == CW'(CAPACITY));
	assign empty  = (count_q == '0);
	assign pop    = !fifo_empty && (!valid_q || m_tready);
	assign do_enq = pop && (op.kind == spq_pkg::KIND_ENQ) && !full;
	assign do_deq = pop && (op.kind == spq_pkg::KIND_DEQ) && !empty;

	// held entries that stay ahead of the new one; a prefix since the row is sorted
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			ge[i] = (CW'(i) < count_q) && (pri_q[i] >= op.prio);
		end
	end

	for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
		if (gi == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (do_enq) begin
					if (!ge[0]) begin
						hnd_q[0] <= op.handle;
						pri_q[0] <= op.prio;
					end
				end else if (do_deq) begin
					hnd_q[0] <= hnd_q[1];
					pri_q[0] <= pri_q[1];
				end
			end
		end else begin : g_body
			always_ff @(posedge clk) begin
				if (do_enq) begin
					if (!ge[gi]) begin
						if (ge[gi-1]) begin
							hnd_q[gi] <= op.handle;
							pri_q[gi] <= op.prio;
						end else begin
							hnd_q[gi] <= hnd_q[gi-1];
							pri_q[gi] <= pri_q[gi-1];
						end
					end
				end else if (do_deq) begin
					if (gi < CAPACITY - 1) begin
						hnd_q[gi] <= hnd_q[(gi < CAPACITY - 1) ? gi + 1 : gi];
						pri_q[gi] <= pri_q[(gi < CAPACITY - 1) ? gi + 1 : gi];
					end
				end
			end
		end
	end

	always_comb begin
		count_nx  = count_q;
		status_nx = spq_pkg::ST_OK;
		front_hnd = hnd_q[0];
		front_pri = pri_q[0];
		if (op.kind == spq_pkg::KIND_ENQ) begin
			if (full) begin
				status_nx = spq_pkg::ST_FULL;
			end else begin
				count_nx = count_q + 1'b1;
				if (!ge[0]) begin
					front_hnd = op.handle;
					front_pri = op.prio;
				end
			end
		end else begin
			if (empty) begin
				status_nx = spq_pkg::ST_EMPTY;
			end else begin
				count_nx  = count_q - 1'b1;
				front_hnd = hnd_q[1];
				front_pri = pri_q[1];
			end
		end
		if (count_nx == '0) begin
			front_hnd = '0;
			front_pri = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (do_enq || do_deq) begin
				count_q <= count_nx;
			end
			if (pop) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res.status   <= status_nx;
			res.handle   <= front_hnd;
			res.prio     <= front_pri;
			res.count    <= spq_pkg::COUNT_W'(count_nx);
			res.is_empty <= (count_nx == '0);
		end
	end

	assign m_tvalid = valid_q;

endmodule
`default_nettype wire

// ===== design/stable_sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue, descending priority, first-in order among ties.
// ----------------------------------------------------------------------------
// Every request on the input stream yields exactly one result on the output
// stream. An enqueue request (tuser 0) computes the entry's priority, times
// ten, from agility and type (x15 agile, x8 tank, x10 physical or magic; zero
// when not alive) and slots the entry in behind all held entries of equal or
// higher priority. A dequeue request (tuser 1) drops the front entry. The
// result gives the front entry's handle and priority after the request (both
// zero when empty), the count, an empty flag and a status in tuser: ok, full
// (enqueue dropped) or empty (dequeue ignored); a rejected request leaves the
// queue as it was. Throughput is one request per clock while the output is
// not stalled: the front computes the priority and writes a four-deep request
// queue in the accept cycle, and the back applies one request a cycle, while
// the result register is free or being taken, to a row of CAPACITY shift
// cells, every cell deciding in parallel whether it holds, takes the new entry
// or takes a neighbor. The back reads a request from the request queue once
// the result register is free or being taken and loads the result register
// at the end of that cycle. Output stalls fill the request queue before
// input ready drops. There is no clearing pass after reset: empty cells are
// tracked by the count alone.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_sorted_priority_queue_assert.svh"
module stable_sorted_priority_queue #(
	parameter int CAPACITY = 16   // 2 .. 31 entries
) (
	input  wire         clk,
	input  wire         arst_n,
	// request stream
	input  wire         s_tvalid,
	output logic        s_tready,
	// [15:0] entry_handle, [23:16] agility, [24] alive, [26:25] entry_type
	input  wire  [31:0] s_tdata,
	// [0] kind: 0 enqueue, 1 dequeue
	input  wire         s_tuser,
	// result stream
	output logic        m_tvalid,
	input  wire         m_tready,
	// [15:0] front_handle, [27:16] front_priority, [32:28] entry_count,
	// [33] is_empty
	output logic [39:0] m_tdata,
	// [1:0] status: 0 ok, 1 full, 2 empty
	output logic [1:0]  m_tuser
);

	logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
	spq_pkg::op_t  push_op, pop_op;
	spq_pkg::res_t res;

	// front: accept and classify
	spq_front u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.fifo_full (fifo_full),
		.push      (fifo_push),
		.push_op   (push_op)
	);

	// decoupling queue
	spq_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fifo_push),
		.push_op (push_op),
		.full    (fifo_full),
		.pop     (fifo_pop),
		.pop_op  (pop_op),
		.empty   (fifo_empty)
	);

	// back: sorted cells and result register
	spq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.op         (pop_op),
		.pop        (fifo_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.res        (res)
	);

	assign m_tdata = {6'b0, res.is_empty, res.count, res.prio, res.handle};
	assign m_tuser = res.status;

	// request queue never overflows or underflows
	`SPQ_NEVER(a_no_overflow, clk, arst_n, fifo_push && fifo_full, "request queue overflow")
	`SPQ_NEVER(a_no_underflow, clk, arst_n, fifo_pop && fifo_empty, "request queue underflow")
	// an ignored dequeue can only report an empty queue
	`SPQ_ASSERT(a_empty_status, clk, arst_n,
		(m_tvalid && m_tuser == spq_pkg::ST_EMPTY) |-> (m_tdata[33] && m_tdata[32:28] == 5'd0),
		"empty status with entries held")
	// an empty result carries no front entry
	`SPQ_ASSERT(a_empty_front, clk, arst_n,
		(m_tvalid && m_tdata[33]) |-> (m_tdata[27:0] == 28'd0),
		"empty result with front entry")

endmodule
`default_nettype wire

// ===== tb/sv/stable_sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_tb
// Self-checking bench for the stable sorted priority queue.
// ----------------------------------------------------------------------------
// A shadow copy of the sorted queue predicts, for every accepted request,
// the status, the front entry, the count and the empty flag. Results are
// checked in order against those predictions. A short directed run covers
// the priority classes, ties and the empty case. A random run then mixes
// fill-heavy, balanced and drain-heavy phases at random, so the queue
// reaches full and empty often. Both stream sides idle at random, and one
// long output stall backs the request queue up until input ready drops.
`timescale 1ns / 1ps
`default_nettype none
module stable_sorted_priority_queue_tb;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 900;
	localparam int HOLD_AT      = 300;     // result count at which the long stall starts
	localparam int HOLD_CYCLES  = 90;
	localparam int LIMIT        = 200000;

	typedef struct packed {
		logic                         kind;
		logic [spq_pkg::HANDLE_W-1:0] handle;
		logic [spq_pkg::AGIL_W-1:0]   agility;
		logic                         alive;
		logic [spq_pkg::ETYPE_W-1:0]  etype;
	} request_t;

	// Shadow of the sorted queue plus the fronts still owed by the block.
	class queue_shadow;
		logic [spq_pkg::HANDLE_W-1:0] handles [DEPTH];
		logic [spq_pkg::PRIO_W-1:0]   ranks [DEPTH];
		int                           held;
		spq_pkg::res_t                pending_fronts [$];
		int                           failures;

		function new();
			held = 0;
			failures = 0;
		endfunction

		function logic [spq_pkg::PRIO_W-1:0] rank_of(request_t r);
			int scaled;
			if (!r.alive)
				return '0;
			case (r.etype)
				spq_pkg::ETYPE_AGILE: scaled = int'(r.agility) * 15;
				spq_pkg::ETYPE_TANK:  scaled = int'(r.agility) * 8;
				default:              scaled = int'(r.agility) * 10;
			endcase
			return spq_pkg::PRIO_W'(scaled);
		endfunction

		function void note_request(request_t r);
			spq_pkg::res_t              e;
			int                         pos;
			int                         i;
			logic [spq_pkg::PRIO_W-1:0] p;
			e.status = spq_pkg::ST_OK;
			if (r.kind == spq_pkg::KIND_ENQ) begin
				if (held >= DEPTH) begin
					e.status = spq_pkg::ST_FULL;
				end else begin
					p = rank_of(r);
					pos = 0;
					// stable: new entry goes behind every equal or higher rank
					while (pos < held && ranks[pos] >= p)
						pos++;
					for (i = held; i > pos; i--) begin
						handles[i] = handles[i-1];
						ranks[i]   = ranks[i-1];
					end
					handles[pos] = r.handle;
					ranks[pos]   = p;
					held++;
				end
			end else begin
				if (held == 0) begin
					e.status = spq_pkg::ST_EMPTY;
				end else begin
					for (i = 1; i < held; i++) begin
						handles[i-1] = handles[i];
						ranks[i-1]   = ranks[i];
					end
					held--;
				end
			end
			e.handle   = (held > 0) ? handles[0] : '0;
			e.prio     = (held > 0) ? ranks[0] : '0;
			e.count    = spq_pkg::COUNT_W'(held);
			e.is_empty = (held == 0);
			pending_fronts.push_back(e);
		endfunction

		// word: [15:0] handle, [27:16] priority, [32:28] count, [33] empty
		function void check_result(logic [39:0] word, logic [1:0] tag);
			spq_pkg::res_t e;
			if (pending_fronts.size() == 0) begin
				$error("result with no request outstanding: tdata %h tuser %0d", word, tag);
				failures++;
				return;
			end
			e = pending_fronts.pop_front();
			if (tag !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, tag);
				failures++;
			end
			if (word[15:0] !== e.handle) begin
				$error("front_handle: expected %h, got %h", e.handle, word[15:0]);
				failures++;
			end
			if (word[27:16] !== e.prio) begin
				$error("front_priority: expected %0d, got %0d", e.prio, word[27:16]);
				failures++;
			end
			if (word[32:28] !== e.count) begin
				$error("entry_count: expected %0d, got %0d", e.count, word[32:28]);
				failures++;
			end
			if (word[33] !== e.is_empty) begin
				$error("is_empty: expected %0d, got %0d", e.is_empty, word[33]);
				failures++;
			end
		endfunction

		function int outstanding();
			return pending_fronts.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	wire         s_tready;
	logic [31:0] s_tdata;
	logic        s_tuser;
	wire         m_tvalid;
	logic        m_tready;
	wire  [39:0] m_tdata;
	wire  [1:0]  m_tuser;

	queue_shadow shadow = new();
	int          cycles = 0;
	bit          send_burst = 1'b0;
	bit          take_burst = 1'b0;

	stable_sorted_priority_queue #(.CAPACITY(DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic request_t make_enq(logic [spq_pkg::HANDLE_W-1:0] h,
			logic [spq_pkg::AGIL_W-1:0] a, logic alv, logic [spq_pkg::ETYPE_W-1:0] t);
		request_t r;
		r.kind    = spq_pkg::KIND_ENQ;
		r.handle  = h;
		r.agility = a;
		r.alive   = alv;
		r.etype   = t;
		return r;
	endfunction

	// data fields of a dequeue are don't-care, so fill them with noise
	function automatic request_t make_deq();
		request_t r;
		r.kind    = spq_pkg::KIND_DEQ;
		r.handle  = spq_pkg::HANDLE_W'($urandom);
		r.agility = spq_pkg::AGIL_W'($urandom);
		r.alive   = 1'($urandom);
		r.etype   = spq_pkg::ETYPE_W'($urandom);
		return r;
	endfunction

	function automatic request_t make_random(int enq_pct);
		request_t r;
		if ($urandom_range(0, 99) < enq_pct) begin
			r = make_enq(spq_pkg::HANDLE_W'($urandom), spq_pkg::AGIL_W'($urandom),
				($urandom_range(0, 7) != 0), spq_pkg::ETYPE_W'($urandom));
			// a few agility values so that priority ties are common
			if ($urandom_range(0, 1) == 0) begin
				case ($urandom_range(0, 3))
					0: r.agility = 8'd0;
					1: r.agility = 8'd1;
					2: r.agility = 8'd17;
					default: r.agility = 8'd255;
				endcase
			end
		end else begin
			r = make_deq();
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic offer_request(request_t r);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  = {5'b0, r.etype, r.alive, r.agility, r.handle};
		s_tuser  = r.kind;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		shadow.note_request(r);
		@(negedge clk);
	endtask

	// result side: random stalls, burst stretches, one long hold-off
	initial begin : result_sink
		int stall;
		int taken;
		taken = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = take_burst ? 0 : $urandom_range(0, 7);
			if (taken == HOLD_AT)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			shadow.check_result(m_tdata, m_tuser);
			taken++;
			if ($urandom_range(0, 39) == 0)
				take_burst = !take_burst;
			@(negedge clk);
		end
	end

	initial begin : request_source
		int sent;
		int phase_len;
		int enq_pct;
		int k;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = spq_pkg::KIND_ENQ;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty dequeue, field extremes, every type, ties, drain
		offer_request(make_deq());
		offer_request(make_enq(16'h0000, 8'd0,   1'b1, spq_pkg::ETYPE_PHYSICAL));
		offer_request(make_enq(16'hFFFF, 8'd255, 1'b1, spq_pkg::ETYPE_AGILE));
		offer_request(make_enq(16'h1111, 8'd255, 1'b0, spq_pkg::ETYPE_TANK));  // dead: ties at zero
		offer_request(make_enq(16'h2222, 8'd255, 1'b1, spq_pkg::ETYPE_TANK));  // 2040
		offer_request(make_enq(16'h3333, 8'd204, 1'b1, spq_pkg::ETYPE_MAGIC)); // 2040, behind tank
		offer_request(make_enq(16'h4444, 8'd255, 1'b1, spq_pkg::ETYPE_PHYSICAL)); // 2550
		offer_request(make_enq(16'h5555, 8'd170, 1'b1, spq_pkg::ETYPE_AGILE)); // 2550 tie
		offer_request(make_enq(16'h6666, 8'd255, 1'b1, spq_pkg::ETYPE_MAGIC)); // 2550 tie
		for (k = 0; k < 9; k++)
			offer_request(make_deq());

		// random: phases biased toward filling or draining
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			phase_len = $urandom_range(20, 80);
			case ($urandom_range(0, 3))
				0: enq_pct = 15;
				1: enq_pct = 50;
				2: enq_pct = 85;
				default: enq_pct = 97;
			endcase
			for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
				offer_request(make_random(enq_pct));
				sent++;
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
			end
		end
		s_tvalid = 1'b0;

		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (shadow.failures == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire

// ===== stable_sorted_priority_queue.f =====
+incdir+design
design/spq_pkg.sv
design/spq_fifo.sv
design/spq_front.sv
design/spq_back.sv
design/stable_sorted_priority_queue.sv
tb/sv/stable_sorted_priority_queue_tb.sv
